FILE: design/msdd_pkg.sv
// Package for the multiplexed seven-segment driver: action codes, segment
// constants, glyph tables and the character decoder. No dependencies.
package msdd_pkg;

  typedef enum logic [2:0] {
    ACT_REFRESH  = 3'd0,
    ACT_CLEAR    = 3'd1,
    ACT_ENABLE   = 3'd2,
    ACT_RAW      = 3'd3,
    ACT_DOT      = 3'd4,
    ACT_UNSIGNED = 3'd5,
    ACT_SIGNED   = 3'd6,
    ACT_TEXT     = 3'd7
  } action_e;

  localparam int unsigned DIGIT_COUNT_DEF     = 4;
  localparam int unsigned SHIFT_MSB_FIRST_DEF = 1;
  localparam int unsigned FRAME_BITS          = 16;
  localparam int unsigned BIN_BITS            = 16;
  localparam int unsigned BCD_DIGITS          = 5;
  localparam int unsigned DASH_DIGITS         = 4;

  localparam logic [7:0] SEG_BLANK   = 8'hff;
  localparam logic [7:0] SEG_MINUS   = 8'hbf;
  localparam int unsigned SEG_DOT_BIT = 7;
  localparam logic [7:0] CHAR_PERIOD = 8'h2e;
  localparam logic [7:0] CHAR_NONE   = 8'h00;

  localparam logic [7:0] NUMERAL_GLYPH [10] = '{
    8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8, 8'h80, 8'h90
  };

  // 'A'..'Z'; blank where a letter has no glyph
  localparam logic [7:0] LETTER_GLYPH [26] = '{
    8'h88, 8'h83, 8'hc6, 8'ha1, 8'h86, 8'h8e, 8'h90, 8'h89, 8'hcf, 8'he1,
    8'hff, 8'hc7, 8'hff, 8'hab, 8'ha3, 8'h8c, 8'h98, 8'haf, 8'h92, 8'h87,
    8'hc1, 8'hff, 8'hff, 8'hff, 8'h91, 8'hff
  };

  function automatic logic [7:0] decode_char(input logic [7:0] c);
    logic [7:0] u;
    logic [7:0] g;
    u = (c inside {[8'h61:8'h7a]}) ? c - 8'h20 : c;
    g = SEG_BLANK;
    if (u inside {[8'h30:8'h39]}) begin
      g = NUMERAL_GLYPH[4'(u - 8'h30)];
    end else if (u inside {[8'h41:8'h5a]}) begin
      g = LETTER_GLYPH[5'(u - 8'h41)];
    end else begin
      case (u)
        8'h2d:   g = 8'hbf;  // '-'
        8'h3d:   g = 8'hb7;  // '='
        8'h5f:   g = 8'hf7;  // '_'
        8'h5b:   g = 8'hc6;  // '['
        8'h5d:   g = 8'hf0;  // ']'
        default: g = SEG_BLANK;
      endcase
    end
    return g;
  endfunction

endpackage

FILE: design/msdd_if.sv
// Handshake interfaces of the seven-segment driver: command channel and
// serial bit channel. No dependencies.
interface msdd_in_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  action;
  logic        [1:0]  digit_position;
  logic        [7:0]  raw_segments;
  logic               dot_on;
  logic               enable_value;
  logic        [15:0] unsigned_number;
  logic signed [15:0] signed_number;
  logic               show_zeros;
  logic        [7:0]  character;
  logic               first_char;
  logic               end_of_text;

  modport source (
    output valid, action, digit_position, raw_segments, dot_on, enable_value,
           unsigned_number, signed_number, show_zeros, character, first_char,
           end_of_text,
    input  ready
  );
  modport sink (
    input  valid, action, digit_position, raw_segments, dot_on, enable_value,
           unsigned_number, signed_number, show_zeros, character, first_char,
           end_of_text,
    output ready
  );
endinterface

interface msdd_out_if;
  logic valid;
  logic ready;
  logic serial_bit;
  logic latch;

  modport source (output valid, serial_bit, latch, input ready);
  modport sink (input valid, serial_bit, latch, output ready);
endinterface

FILE: design/msdd_bcd.sv
// Bit-serial binary to BCD converter (shift and add 3), one bit per cycle.
// Depends on msdd_pkg.
module msdd_bcd
  import msdd_pkg::*;
(
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [BIN_BITS-1:0]             value_i,
  output logic                            done_o,
  output logic [BCD_DIGITS-1:0][3:0]      digits_o
);

  localparam int unsigned CntW = $clog2(BIN_BITS);

  logic [BCD_DIGITS-1:0][3:0] bcd_q, bcd_d, adj;
  logic [BIN_BITS-1:0]        bin_q, bin_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [BCD_DIGITS*4+BIN_BITS-1:0] cat;

  always_comb begin
    for (int k = 0; k < BCD_DIGITS; k++) begin
      adj[k] = (bcd_q[k] >= 4'd5) ? bcd_q[k] + 4'd3 : bcd_q[k];
    end
    cat    = {adj, bin_q} << 1;
    bcd_d  = bcd_q;
    bin_d  = bin_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      bcd_d  = '0;
      bin_d  = value_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d = cat[BCD_DIGITS*4+BIN_BITS-1:BIN_BITS];
      bin_d = cat[BIN_BITS-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(BIN_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
    bin_q <= bin_d;
  end

  assign done_o   = done_q;
  assign digits_o = bcd_q;

endmodule

FILE: design/msdd_shift.sv
// Frame serializer: loads segment and select bytes, shifts one bit per
// output transaction and marks the last bit. Depends on msdd_pkg, msdd_if.
module msdd_shift
  import msdd_pkg::*;
#(
  parameter int unsigned SHIFT_MSB_FIRST = SHIFT_MSB_FIRST_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [7:0]        segs_i,
  input  logic [7:0]        sel_i,
  output logic              busy_o,
  msdd_out_if.source        out_o
);

  localparam int unsigned CntW = $clog2(FRAME_BITS);

  logic [FRAME_BITS-1:0] sr_q, sr_d, load_word;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic [7:0]            segs_r, sel_r;
  logic                  last_bit;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      segs_r[i] = segs_i[7-i];
      sel_r[i]  = sel_i[7-i];
    end
    // first bit out sits at the MSB of the shift word
    load_word = (SHIFT_MSB_FIRST != 0) ? {segs_i, sel_i} : {segs_r, sel_r};
  end

  assign last_bit = (cnt_q == CntW'(FRAME_BITS - 1));

  always_comb begin
    sr_d   = sr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (load_i && !busy_q) begin
      sr_d   = load_word;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q && out_o.ready) begin
      sr_d  = sr_q << 1;
      cnt_d = cnt_q + 1'b1;
      if (last_bit) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q <= sr_d;
  end

  assign out_o.valid      = busy_q;
  assign out_o.serial_bit = sr_q[FRAME_BITS-1];
  assign out_o.latch      = last_bit;
  assign busy_o           = busy_q;

endmodule

FILE: design/multiplexed_seven_segment_driver_unit.sv
// Multiplexed seven-segment driver, top level: digit store, text and number
// sequencing. Depends on msdd_pkg, msdd_if, msdd_bcd and msdd_shift.
//
// The block holds one active-low segment byte per digit (DIGIT_COUNT digits,
// blank after reset) and takes one command transaction at a time on in_i.
// Raw, dot, enable-on and text-character commands complete while idle and
// give no output. Unsigned and signed number writes run the value through a
// bit-serial BCD converter before the store is updated. A refresh tick
// (when enabled), a clear, or a disable loads a 16-bit frame, segment byte
// then one-hot select byte, bit order per SHIFT_MSB_FIRST, and sends it as
// 16 transactions on out_o, one bit per cycle while out_o.ready is high;
// latch is high on the sixteenth bit. in_i.ready stays low until the frame
// is out, also while the sink stalls. Clear and disable send a blank frame
// with no digit selected.
module multiplexed_seven_segment_driver_unit
  import msdd_pkg::*;
#(
  parameter int unsigned DIGIT_COUNT     = DIGIT_COUNT_DEF,
  parameter int unsigned SHIFT_MSB_FIRST = SHIFT_MSB_FIRST_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  msdd_in_if.sink     in_i,
  msdd_out_if.source  out_o
);

  localparam int unsigned PosW = $clog2(DIGIT_COUNT);
  localparam int unsigned TpW  = $clog2(DIGIT_COUNT + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_SEND = 3'b100
  } state_e;

  state_e                      state_q, state_d;
  logic [7:0]                  store_q [DIGIT_COUNT];
  logic [7:0]                  store_d [DIGIT_COUNT];
  logic [PosW-1:0]             scan_q, scan_d;
  logic                        en_q, en_d;
  logic [TpW-1:0]              tp_q, tp_d;
  logic                        neg_q, neg_d;     // signed write, negative value
  logic                        zeros_q, zeros_d; // show leading zeros

  logic                        load;
  logic [7:0]                  frame_segs, frame_sel;
  logic                        send_busy;
  logic                        conv_start, conv_done;
  logic [BIN_BITS-1:0]         conv_value;
  logic [BCD_DIGITS-1:0][3:0]  conv_digits;
  logic [PosW-1:0]             pos_idx;
  logic                        pos_ok;

  assign pos_idx = PosW'(in_i.digit_position);
  assign pos_ok  = (32'(in_i.digit_position) < DIGIT_COUNT);

  // negative signed values convert their magnitude
  assign conv_value =
    (in_i.action == ACT_SIGNED && in_i.signed_number[15]) ?
      BIN_BITS'(~in_i.signed_number + 16'sd1) :
    (in_i.action == ACT_SIGNED) ? BIN_BITS'(in_i.signed_number) :
    in_i.unsigned_number;

  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    logic [TpW-1:0] tp_v;
    logic           started;
    logic           ovf;
    logic [3:0]     d;
    int             lim;
    int             idx;

    state_d    = state_q;
    store_d    = store_q;
    scan_d     = scan_q;
    en_d       = en_q;
    tp_d       = tp_q;
    neg_d      = neg_q;
    zeros_d    = zeros_q;
    load       = 1'b0;
    frame_segs = SEG_BLANK;
    frame_sel  = 8'h00;
    conv_start = 1'b0;
    tp_v       = tp_q;
    started    = 1'b0;
    ovf        = 1'b0;
    d          = 4'd0;
    lim        = 0;
    idx        = 0;

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          case (in_i.action)
            ACT_REFRESH: begin
              if (en_q) begin
                frame_segs = store_q[scan_q];
                frame_sel  = 8'h01 << scan_q;
                load       = 1'b1;
                state_d    = ST_SEND;
                scan_d     = (scan_q == PosW'(DIGIT_COUNT - 1)) ? '0 : scan_q + 1'b1;
              end
            end
            ACT_CLEAR: begin
              for (int i = 0; i < DIGIT_COUNT; i++) store_d[i] = SEG_BLANK;
              load    = 1'b1;
              state_d = ST_SEND;
            end
            ACT_ENABLE: begin
              en_d = in_i.enable_value;
              if (!in_i.enable_value) begin
                load    = 1'b1;
                state_d = ST_SEND;
              end
            end
            ACT_RAW: begin
              if (pos_ok) store_d[pos_idx] = in_i.raw_segments;
            end
            ACT_DOT: begin
              if (pos_ok) store_d[pos_idx][SEG_DOT_BIT] = ~in_i.dot_on;
            end
            ACT_UNSIGNED, ACT_SIGNED: begin
              neg_d      = (in_i.action == ACT_SIGNED) && in_i.signed_number[15];
              zeros_d    = in_i.show_zeros;
              conv_start = 1'b1;
              state_d    = ST_CONV;
            end
            default: begin  // text character
              if (in_i.first_char) tp_v = '0;
              if (in_i.character != CHAR_NONE) begin
                if (32'(tp_v) < DIGIT_COUNT) begin
                  if (in_i.character == CHAR_PERIOD) begin
                    // dot on previous digit; no digit taken
                    if (tp_v != '0) store_d[PosW'(tp_v - 1'b1)][SEG_DOT_BIT] = 1'b0;
                  end else begin
                    store_d[PosW'(tp_v)] = decode_char(in_i.character);
                    tp_v = tp_v + 1'b1;
                  end
                end
              end
              // end of text or a null character blanks the unfilled digits
              if (in_i.character == CHAR_NONE || in_i.end_of_text) begin
                for (int i = 0; i < DIGIT_COUNT; i++) begin
                  if (TpW'(i) >= tp_v) store_d[i] = SEG_BLANK;
                end
                tp_v = TpW'(DIGIT_COUNT);
              end
              tp_d = tp_v;
            end
          endcase
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          // out of range: any nonzero BCD digit at or above the available digits
          lim = neg_q ? DIGIT_COUNT - 1 : DIGIT_COUNT;
          for (int k = 0; k < BCD_DIGITS; k++) begin
            if (k >= lim && conv_digits[k] != 4'd0) ovf = 1'b1;
          end
          if (ovf) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
              store_d[i] = (i < DASH_DIGITS) ? SEG_MINUS : SEG_BLANK;
            end
          end else begin
            started = zeros_q;
            for (int p = 0; p < DIGIT_COUNT; p++) begin
              if (neg_q && p == 0) begin
                store_d[p] = SEG_MINUS;
              end else begin
                idx = DIGIT_COUNT - 1 - p;
                d   = (idx < BCD_DIGITS) ? conv_digits[3'(idx)] : 4'd0;
                if (d != 4'd0 || p == DIGIT_COUNT - 1) started = 1'b1;
                store_d[p] = started ? NUMERAL_GLYPH[d] : SEG_BLANK;
              end
            end
          end
          state_d = ST_IDLE;
        end
      end
      ST_SEND: begin
        if (!send_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      for (int i = 0; i < DIGIT_COUNT; i++) store_q[i] <= SEG_BLANK;
      scan_q  <= '0;
      en_q    <= 1'b1;
      tp_q    <= '0;
    end else begin
      state_q <= state_d;
      store_q <= store_d;
      scan_q  <= scan_d;
      en_q    <= en_d;
      tp_q    <= tp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q   <= neg_d;
    zeros_q <= zeros_d;
  end

  msdd_bcd u_bcd (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (conv_start),
    .value_i  (conv_value),
    .done_o   (conv_done),
    .digits_o (conv_digits)
  );

  msdd_shift #(
    .SHIFT_MSB_FIRST (SHIFT_MSB_FIRST)
  ) u_shift (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .segs_i (frame_segs),
    .sel_i  (frame_sel),
    .busy_o (send_busy),
    .out_o  (out_o)
  );

endmodule
